// ===== rtl/sm3_pkg.sv =====
package sm3_pkg;

    // One message word as it travels from the front queue to the back end.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } item_t;

    typedef logic [31:0] word8_t [8];
    typedef logic [31:0] word16_t [16];

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [2:0]  MAX_BYTES = 3'd4;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [31:0] T_LOW     = 32'h79CC4519;
    localparam logic [31:0] T_HIGH    = 32'h7A879D8A;

    localparam word8_t INIT_VECTOR = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // Rotate left by an amount fixed at each call site.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} << (n % 32);
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 9) ^ rotl32(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 15) ^ rotl32(x, 23);
    endfunction

    // Round constant of round sixteen, the first one that uses T_HIGH.
    localparam logic [31:0] T_HIGH16 = rotl32(T_HIGH, 16);

endpackage

// ===== rtl/sm3_front.sv =====
module sm3_front
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        full,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_take
);

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;
    item_t             in_item;

    // Clamp the byte count so the back end never sees more than four bytes.
    always_comb
    begin
        in_item.data   = data_word;
        in_item.nbytes = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
        in_item.last   = last_word;
    end

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sm3_back.sv =====
module sm3_back
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_take,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTES,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_LOAD,
        S_COMP,
        S_EMIT
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [31:0] data_reg, data_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [63:0] len_reg, len_next;
    logic [60:0] total_reg, total_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] tj_reg, tj_next;
    logic [2:0]  idx_reg, idx_next;
    word16_t     buf_reg, buf_next;
    word16_t     win_reg, win_next;
    word8_t      cv_reg, cv_next;
    word8_t      work_reg, work_next;

    logic        put;
    logic [7:0]  put_data;
    state_t      put_ret;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
    word8_t      rnd_out;

    // One compression round and the next expanded message word.
    always_comb
    begin
        a12 = rotl32(work_reg[0], 12);
        ss1 = rotl32(a12 + work_reg[4] + tj_reg, 7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
               | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ff + work_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + work_reg[7] + ss1 + win_reg[0];
        rnd_out[0] = tt1;
        rnd_out[1] = work_reg[0];
        rnd_out[2] = rotl32(work_reg[1], 9);
        rnd_out[3] = work_reg[2];
        rnd_out[4] = perm0(tt2);
        rnd_out[5] = work_reg[4];
        rnd_out[6] = rotl32(work_reg[5], 19);
        rnd_out[7] = work_reg[6];
        wnew = perm1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 15))
             ^ rotl32(win_reg[3], 7) ^ win_reg[10];
    end

    // Sequencer: byte packing, padding, compression and digest readout.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        len_next   = len_reg;
        total_next = total_reg;
        fill_next  = fill_reg;
        rnd_next   = rnd_reg;
        tj_next    = tj_reg;
        idx_next   = idx_reg;
        buf_next   = buf_reg;
        win_next   = win_reg;
        cv_next    = cv_reg;
        work_next  = work_reg;
        q_take     = 1'b0;
        put        = 1'b0;
        put_data   = 8'h00;
        put_ret    = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take     = 1'b1;
                    data_next  = q_item.data;
                    cnt_next   = q_item.nbytes;
                    last_next  = q_item.last;
                    state_next = S_BYTES;
                end
            end
            S_BYTES:
            begin
                if (cnt_reg == 3'd0)
                begin
                    if (last_reg)
                    begin
                        len_next   = {total_reg, 3'b000};
                        state_next = S_PAD80;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    put        = 1'b1;
                    put_data   = data_reg[31:24];
                    put_ret    = S_BYTES;
                    data_next  = {data_reg[23:0], 8'h00};
                    cnt_next   = cnt_reg - 3'd1;
                    total_next = total_reg + 61'd1;
                end
            end
            S_PAD80:
            begin
                put        = 1'b1;
                put_data   = PAD_BYTE;
                put_ret    = S_PADZ;
                state_next = S_PADZ;
            end
            S_PADZ:
            begin
                if (fill_reg == 6'd56)
                begin
                    state_next = S_PADLEN;
                end
                else
                begin
                    put     = 1'b1;
                    put_ret = S_PADZ;
                end
            end
            S_PADLEN:
            begin
                // The length always ends exactly on the last byte of a block.
                put      = 1'b1;
                put_data = len_reg[63:56];
                put_ret  = S_EMIT;
                len_next = {len_reg[55:0], 8'h00};
            end
            S_LOAD:
            begin
                win_next   = buf_reg;
                work_next  = cv_reg;
                rnd_next   = '0;
                tj_next    = T_LOW;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                work_next = rnd_out;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = wnew;
                rnd_next     = rnd_reg + 6'd1;
                tj_next      = (rnd_reg == 6'd15) ? T_HIGH16 : rotl32(tj_reg, 1);
                if (rnd_reg == 6'd63)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_next[i] = cv_reg[i] ^ rnd_out[i];
                    end
                    state_next = ret_reg;
                end
            end
            S_EMIT:
            begin
                if (pop)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        idx_next   = '0;
                        cv_next    = INIT_VECTOR;
                        total_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Byte insertion into the block buffer; a full block starts compression.
        if (put)
        begin
            case (fill_reg[1:0])
                2'd0:    buf_next[fill_reg[5:2]][31:24] = put_data;
                2'd1:    buf_next[fill_reg[5:2]][23:16] = put_data;
                2'd2:    buf_next[fill_reg[5:2]][15:8]  = put_data;
                default: buf_next[fill_reg[5:2]][7:0]   = put_data;
            endcase
            fill_next = fill_reg + 6'd1;
            if (fill_reg == 6'd63)
            begin
                ret_next   = put_ret;
                state_next = S_LOAD;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            total_reg <= '0;
            fill_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            cv_reg    <= INIT_VECTOR;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            total_reg <= total_next;
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            cv_reg    <= cv_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        len_reg  <= len_next;
        tj_reg   <= tj_next;
        buf_reg  <= buf_next;
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    assign empty       = (state_reg != S_EMIT);
    assign digest_word = cv_reg[idx_reg];
    assign word_index  = idx_reg;
    assign digest_done = (idx_reg == 3'd7);

endmodule

// ===== rtl/sm3_hash_engine.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------
// message   | push / full        | data_word, valid_bytes, last_word
// digest    | pop / empty        | digest_word, word_index, digest_done
//
// A full word is taken, its four bytes are packed one by one, then the word is closed.
// Each 64-byte block runs through the single shared round unit: a load, then 64 rounds.
// A last word adds the padding bytes and one or two compressions.
// A four-entry queue takes words while the back end works or the digest waits.
// Reset is asynchronous and active low; no clearing pass is needed.
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_done
);

    logic  q_valid;
    logic  q_take;
    item_t q_item;

    // Front end: accepts, clamps and queues message words.
    sm3_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .full        (full),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take)
    );

    // Back end: packing, padding, compression and digest readout.
    sm3_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_done (digest_done)
    );

    // A waiting digest word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(word_index) && $stable(digest_word)))
        else $error("digest word changed while stalled");

    // Taking the final digest word ends the digest.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && digest_done) |=> empty)
        else $error("digest continued after final word");

    // Taking any other word moves to the next index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !digest_done) |=>
            (!empty && word_index == $past(word_index) + 3'd1))
        else $error("digest word index skipped");

endmodule
